// ----- hdl/sprite_quad_setup_top_macros.svh -----
// assertion macros for the sprite quad setup block
// used by sprite_quad_setup_top; expects clk and rst in scope
`ifndef SPRITE_QUAD_SETUP_TOP_MACROS_SVH
`define SPRITE_QUAD_SETUP_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SQS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SQS_ASSERT(lbl, expr, msg)
`define SQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/sqs_pkg.sv -----
// shared types, constants and helpers for the sprite quad setup block
// no dependencies
package sqs_pkg;

  localparam int MAX_LAYERS     = 256;
  localparam int MAX_IMAGE_SIZE = 4096;
  localparam int LCNT_W = $clog2(MAX_LAYERS + 1);
  localparam int DIM_W  = $clog2(MAX_IMAGE_SIZE + 1);
  localparam int DEN2_W = DIM_W + 1;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_TEX = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic        new_layer;
    logic [7:0]  layer_index;
    logic [25:0] image_size;
    logic [25:0] rect_origin;
    logic [25:0] rect_end;
    logic [47:0] position;
    logic [31:0] scale;
    logic [47:0] rot_center;
    logic [31:0] rot_cossin;
    logic [31:0] color;
  } sqs_entry_t;

  // zero dimension reads as one, oversize clamps to the maximum
  function automatic logic [DIM_W-1:0] dim_fix(input logic [12:0] v);
    logic [DIM_W:0] d;
    d = (DIM_W + 1)'(v);
    if (d == '0) d = (DIM_W + 1)'(1);
    if (d > (DIM_W + 1)'(MAX_IMAGE_SIZE)) d = (DIM_W + 1)'(MAX_IMAGE_SIZE);
    return d[DIM_W-1:0];
  endfunction

  // vertex number to quad corner, triangles 0,1,2 and 0,2,3
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd0;
      3'd4: c = 2'd2;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [30:0] v);
    logic signed [23:0] r;
    if (v > 31'sd8388607) r = 24'sh7FFFFF;
    else if (v < -31'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ----- hdl/sqs_front.sv -----
// front end: accepts sprites, tracks texture layers, classifies errors
// depends on sqs_pkg
module sqs_front import sqs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        clear_first,
  input  logic [31:0] texture_id,
  input  logic [25:0] image_size,
  input  logic [25:0] rect_origin,
  input  logic [25:0] rect_end,
  input  logic [47:0] position,
  input  logic [31:0] scale,
  input  logic [47:0] rot_center,
  input  logic [31:0] rot_cossin,
  input  logic [31:0] color_in,
  output logic        q_wr,
  output sqs_entry_t  q_data,
  input  logic        q_full
);

  logic [31:0]       last_texture, last_texture_next, last_eff;
  logic [LCNT_W-1:0] layer_count, layer_count_next, cnt_eff;
  logic [1:0]        stat;
  logic              nl;

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  always_comb begin
    cnt_eff = clear_first ? '0 : layer_count;
    last_eff = clear_first ? '0 : last_texture;
    layer_count_next = cnt_eff;
    last_texture_next = last_eff;
    stat = ST_OK;
    nl = 1'b0;
    if (texture_id == '0) begin
      stat = ST_NO_TEX;
    end else if (cnt_eff == '0 || texture_id != last_eff) begin
      if (cnt_eff >= LCNT_W'(MAX_LAYERS)) begin
        stat = ST_FULL;
      end else begin
        layer_count_next = cnt_eff + LCNT_W'(1);
        last_texture_next = texture_id;
        nl = 1'b1;
      end
    end
  end

  always_comb begin
    q_data.status      = stat;
    q_data.new_layer   = (stat == ST_OK) ? nl : 1'b0;
    q_data.layer_index = (stat == ST_OK) ? 8'(layer_count_next - LCNT_W'(1)) : 8'd0;
    q_data.image_size  = image_size;
    q_data.rect_origin = rect_origin;
    q_data.rect_end    = rect_end;
    q_data.position    = position;
    q_data.scale       = scale;
    q_data.rot_center  = rot_center;
    q_data.rot_cossin  = rot_cossin;
    q_data.color       = color_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
      last_texture <= '0;
    end else if (q_wr) begin
      layer_count <= layer_count_next;
      last_texture <= last_texture_next;
    end
  end

endmodule

// ----- hdl/sqs_queue.sv -----
// short queue between front and back ends
// depends on sqs_pkg
module sqs_queue import sqs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  sqs_entry_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output sqs_entry_t rd_data,
  output logic       empty
);

  sqs_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (rd_en) rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (wr_en && !rd_en) count <= count + QCNT_W'(1);
      else if (rd_en && !wr_en) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ----- hdl/sqs_back.sv -----
// back end: texture coordinate divider, corner rotation on one multiplier,
// six-vertex emission; depends on sqs_pkg
module sqs_back import sqs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sqs_entry_t        q_data,
  input  logic              q_empty,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [23:0] vert_x,
  output logic signed [23:0] vert_y,
  output logic signed [17:0] tex_s,
  output logic signed [17:0] tex_t,
  output logic [31:0]       color_out,
  output logic [7:0]        layer_index,
  output logic              new_layer,
  output logic [1:0]        status,
  output logic              last
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} st_t;
  typedef enum logic [2:0] {G_WX, G_HY, G_HYW, G_CORNER, G_DONE} gst_t;

  localparam logic [5:0] DC_FIN  = 6'd32;
  localparam logic [5:0] DC_LOAD = 6'd33;

  st_t  st;
  gst_t gst;

  logic [1:0]  stat;
  logic        nl;
  logic [7:0]  lidx;
  logic [31:0] color;
  logic [DIM_W-1:0] iw, ih;
  logic signed [14:0] w, h;
  logic signed [14:0] num [4];
  logic signed [23:0] px, py, cx, cy;
  logic signed [15:0] sx, sy, cs, sn;
  logic signed [24:0] wx, hy;
  logic signed [26:0] dx, dy;
  logic signed [42:0] p, acc;
  logic signed [23:0] vx [4];
  logic signed [23:0] vy [4];
  logic signed [17:0] tc [4];
  logic [2:0] gk, k;
  logic [1:0] gci;

  logic [1:0]  div_idx;
  logic [5:0]  dcnt;
  logic [31:0] dq;
  logic [DEN2_W-1:0] drem;
  logic        div_neg, div_done;

  // setup from queue head
  logic [DIM_W-1:0] iw_n, ih_n;
  logic signed [14:0] left_n, top_n, wr_n, hr_n, w_n, h_n;

  always_comb begin
    iw_n = dim_fix(q_data.image_size[25:13]);
    ih_n = dim_fix(q_data.image_size[12:0]);
    left_n = $signed({2'b00, q_data.rect_origin[25:13]});
    top_n  = $signed({2'b00, q_data.rect_origin[12:0]});
    wr_n = $signed({2'b00, q_data.rect_end[25:13]}) - left_n;
    hr_n = $signed({2'b00, q_data.rect_end[12:0]}) - top_n;
    w_n = (wr_n > $signed(15'(iw_n))) ? $signed(15'(iw_n)) : wr_n;
    h_n = (hr_n > $signed(15'(ih_n))) ? $signed(15'(ih_n)) : hr_n;
  end

  // divider datapath
  logic [DIM_W-1:0]  den;
  logic [DEN2_W-1:0] den2;
  logic signed [32:0] nn;
  logic              nn_neg;
  logic [31:0]       mag;
  logic [DEN2_W:0]   rsh;
  logic              ge;
  logic [32:0]       qa;
  logic signed [17:0] qsat;

  always_comb begin
    den = div_idx[1] ? ih : iw;
    den2 = {den, 1'b0};
    nn = $signed({num[div_idx][14], num[div_idx], 17'b0}) + $signed(33'(den));
    nn_neg = nn[32];
    mag = nn_neg ? 32'(-nn) : nn[31:0];
    rsh = {drem, dq[31]};
    ge = (rsh >= {1'b0, den2});
    qa = {1'b0, dq} + 33'(drem != '0);
    if (!div_neg) begin
      qsat = (dq > 32'd131071) ? 18'sh1FFFF : $signed(dq[17:0]);
    end else begin
      qsat = (qa > 33'd131072) ? 18'sh20000 : $signed(18'(~qa[17:0] + 18'd1));
    end
  end

  // corner positions and shared multiplier
  logic signed [25:0] cxn, cyn;
  logic signed [26:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [42:0] p_rnd6;
  logic signed [43:0] rsum;
  logic signed [30:0] rot;

  always_comb begin
    if (gci == 2'd1 || gci == 2'd2) cxn = (sx >= 0) ? 26'(px) + 26'(wx) : 26'(px);
    else cxn = (sx >= 0) ? 26'(px) : 26'(px) - 26'(wx);
    if (gci == 2'd2 || gci == 2'd3) cyn = (sy >= 0) ? 26'(py) + 26'(hy) : 26'(py);
    else cyn = (sy >= 0) ? 26'(py) : 26'(py) - 26'(hy);
    mul_a = 27'(w);
    mul_b = sx;
    case (gst)
      G_WX: begin
        mul_a = 27'(w);
        mul_b = sx;
      end
      G_HY: begin
        mul_a = 27'(h);
        mul_b = sy;
      end
      G_CORNER: begin
        case (gk)
          3'd1: begin mul_a = dx; mul_b = cs; end
          3'd2: begin mul_a = dy; mul_b = sn; end
          3'd3: begin mul_a = dy; mul_b = cs; end
          3'd4: begin mul_a = dx; mul_b = sn; end
          default: begin mul_a = dx; mul_b = cs; end
        endcase
      end
      default: begin
        mul_a = 27'(w);
        mul_b = sx;
      end
    endcase
    p_rnd6 = p + 43'sd32;
    rsum = (gk == 3'd3) ? 44'(acc) + 44'(p) : 44'(acc) - 44'(p);
    rsum = rsum + 44'sd8192;
    rot = (gk == 3'd3) ? 31'(cx) + 31'($signed(rsum[43:14])) :
                         31'(cy) + 31'($signed(rsum[43:14]));
  end

  assign q_rd = (st == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      gst <= G_DONE;
      div_done <= 1'b0;
      div_idx <= '0;
      dcnt <= DC_LOAD;
      k <= '0;
      gk <= '0;
      gci <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (!q_empty) begin
            stat <= q_data.status;
            nl <= q_data.new_layer;
            lidx <= q_data.layer_index;
            color <= q_data.color;
            iw <= iw_n;
            ih <= ih_n;
            w <= w_n;
            h <= h_n;
            num[0] <= left_n;
            num[1] <= left_n + w_n;
            num[2] <= $signed(15'(ih_n)) - top_n;
            num[3] <= $signed(15'(ih_n)) - top_n - h_n;
            px <= q_data.position[47:24];
            py <= q_data.position[23:0];
            sx <= q_data.scale[31:16];
            sy <= q_data.scale[15:0];
            cx <= q_data.rot_center[47:24];
            cy <= q_data.rot_center[23:0];
            cs <= q_data.rot_cossin[31:16];
            sn <= q_data.rot_cossin[15:0];
            k <= '0;
            div_idx <= '0;
            dcnt <= DC_LOAD;
            div_done <= 1'b0;
            gst <= G_WX;
            gk <= '0;
            gci <= '0;
            st <= (q_data.status != ST_OK) ? S_EMIT : S_CALC;
          end
        end
        S_CALC: begin
          // texture coordinate divider, one quotient bit per cycle
          if (!div_done) begin
            if (dcnt == DC_LOAD) begin
              dq <= mag;
              drem <= '0;
              div_neg <= nn_neg;
              dcnt <= '0;
            end else if (dcnt == DC_FIN) begin
              tc[div_idx] <= qsat;
              if (div_idx == 2'd3) begin
                div_done <= 1'b1;
              end else begin
                div_idx <= div_idx + 2'd1;
                dcnt <= DC_LOAD;
              end
            end else begin
              dq <= {dq[30:0], ge};
              drem <= ge ? DEN2_W'(rsh - {1'b0, den2}) : rsh[DEN2_W-1:0];
              dcnt <= dcnt + 6'd1;
            end
          end
          // geometry sequencer
          case (gst)
            G_WX: begin
              p <= mul_a * mul_b;
              gst <= G_HY;
            end
            G_HY: begin
              p <= mul_a * mul_b;
              wx <= p_rnd6[30:6];
              gst <= G_HYW;
            end
            G_HYW: begin
              hy <= p_rnd6[30:6];
              gst <= G_CORNER;
            end
            G_CORNER: begin
              case (gk)
                3'd0: begin
                  dx <= 27'(cxn) - 27'(cx);
                  dy <= 27'(cyn) - 27'(cy);
                end
                3'd1: p <= mul_a * mul_b;
                3'd2: begin
                  acc <= p;
                  p <= mul_a * mul_b;
                end
                3'd3: begin
                  vx[gci] <= sat24(rot);
                  p <= mul_a * mul_b;
                end
                3'd4: begin
                  acc <= p;
                  p <= mul_a * mul_b;
                end
                default: vy[gci] <= sat24(rot);
              endcase
              if (gk == 3'd5) begin
                gk <= '0;
                gci <= gci + 2'd1;
                if (gci == 2'd3) gst <= G_DONE;
              end else begin
                gk <= gk + 3'd1;
              end
            end
            default: ;
          endcase
          if (div_done && gst == G_DONE) begin
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (last) st <= S_IDLE;
            else k <= k + 3'd1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // output fields come from held registers, stable while stalled
  logic [1:0] c;
  logic       err;

  always_comb begin
    c = corner_of(k);
    err = (stat != ST_OK);
    out_valid = (st == S_EMIT);
    status = stat;
    last = err || (k == 3'd5);
    vert_x = err ? '0 : vx[c];
    vert_y = err ? '0 : vy[c];
    tex_s = err ? '0 : ((c == 2'd0 || c == 2'd3) ? tc[0] : tc[1]);
    tex_t = err ? '0 : ((c == 2'd0 || c == 2'd1) ? tc[2] : tc[3]);
    color_out = err ? '0 : color;
    layer_index = err ? '0 : lidx;
    new_layer = err ? 1'b0 : nl;
  end

endmodule

// ----- hdl/sprite_quad_setup_top.sv -----
// top level of the sprite quad setup block
// depends on sqs_pkg, sqs_front, sqs_queue, sqs_back and the macros header
//
//  channel | direction | handshake           | payload
//  in      | into      | in_valid / in_stall | one sprite description
//  out     | out of    | out_valid/out_stall | one vertex, or one error result
//
// in the back end a sprite is first taken from the queue, then four texture divisions run
// on one shared bit-serial divider while the corner rotation runs beside them on one
// multiplier; six vertex transfers then follow, one per cycle while out_stall is low.
// an error sprite is taken from the queue and goes straight to its single transfer.
// reset (rst, synchronous) empties the queue and clears layer count and last texture.
// the front keeps taking sprites into a two-entry queue while the back works
// or its output is stalled; in_stall rises only when the queue is full.
`include "sprite_quad_setup_top_macros.svh"
module sprite_quad_setup_top import sqs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              clear_first,
  input  logic [31:0]       texture_id,
  input  logic [25:0]       image_size,
  input  logic [25:0]       rect_origin,
  input  logic [25:0]       rect_end,
  input  logic [47:0]       position,
  input  logic [31:0]       scale,
  input  logic [47:0]       rot_center,
  input  logic [31:0]       rot_cossin,
  input  logic [31:0]       color_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [23:0] vert_x,
  output logic signed [23:0] vert_y,
  output logic signed [17:0] tex_s,
  output logic signed [17:0] tex_t,
  output logic [31:0]       color_out,
  output logic [7:0]        layer_index,
  output logic              new_layer,
  output logic [1:0]        status,
  output logic              last
);

  // queue between front and back
  sqs_entry_t wr_data, rd_data;
  logic       q_wr, q_rd, q_full, q_empty;

  // front: layer tracking and error classification
  sqs_front u_front (
    .clk, .rst, .in_valid, .in_stall, .clear_first, .texture_id, .image_size,
    .rect_origin, .rect_end, .position, .scale, .rot_center, .rot_cossin,
    .color_in, .q_wr, .q_data(wr_data), .q_full
  );

  sqs_queue u_queue (
    .clk, .rst, .wr_en(q_wr), .wr_data, .full(q_full),
    .rd_en(q_rd), .rd_data, .empty(q_empty)
  );

  // back: divider, rotation, vertex emission
  sqs_back u_back (
    .clk, .rst, .q_data(rd_data), .q_empty, .q_rd, .out_valid, .out_stall,
    .vert_x, .vert_y, .tex_s, .tex_t, .color_out, .layer_index, .new_layer,
    .status, .last
  );

  // an error result stands alone and carries no layer
  `SQS_ASSERT(a_err_single, !out_valid || status == ST_OK || (last && !new_layer && layer_index == 8'd0), "error result must be single and empty")
  // queue never reads empty nor writes full
  `SQS_ASSERT(a_queue_ok, !(q_rd && q_empty) && !(q_wr && q_full), "queue overrun or underrun")
  // a last transfer frees the back end, so the next cycle shows no result
  `SQS_ASSERT_NEXT(a_gap_after_last, out_valid && !out_stall && last, !out_valid, "result right after last transfer")

endmodule
